### rtl/core/sawlc_pkg.sv
// ----------------------------------------------------------------------------
// sawlc_pkg
// Shared types and constants of the set-associative write-back LRU cache.
// ----------------------------------------------------------------------------
`default_nettype none
package sawlc_pkg;

  localparam int SETS         = 4;
  localparam int WAYS         = 2;
  localparam int LINE_WORDS   = 64;
  localparam int TAGS_PER_SET = 16;

  localparam int SET_W  = 2;
  localparam int TAG_W  = 4;
  localparam int OFF_W  = 6;
  localparam int CMD_W  = 2;
  localparam int WORD_W = 32;

  localparam int LINE_ADDR_W = SET_W + 1 + OFF_W;     // set, way, offset
  localparam int BACK_ADDR_W = SET_W + TAG_W + OFF_W; // row, offset

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [SET_W-1:0]         set_index;
    logic [TAG_W-1:0]         tag;
    logic [OFF_W-1:0]         word_offset;
    logic signed [WORD_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic                     hit;
    logic                     wrote_back;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/set_assoc_writeback_lru_cache_top.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache_top
// Two-way write-back, write-allocate cache over an internal backing store.
// ----------------------------------------------------------------------------
// Usage: raise start with in_item while busy is low; the beat is taken at
// that edge and busy stays high until the result has been shown. Each result
// is on out_item for one cycle with out_valid high; the receiver cannot stall.
// A load or unknown command shows its result in the cycle after the beat is
// taken, and busy covers that cycle, so no new beat is taken before the
// result has been shown. A hit goes through lookup, line memory access and
// result (S_LOOK, S_ACC, S_DONE) before its result is shown. A miss with a
// clean victim adds a 64-word fill from the backing memory (S_FILL); a
// dirty victim first adds a 64-word write-back (S_WB). Both memories have
// one port, one word a cycle, which sets the miss cost. Tags, valid, dirty
// and LRU bits sit in flip-flops. Reset clears valid, dirty, tags and sets
// the LRU order to way order; the word memories are not cleared and need no
// sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_writeback_lru_cache_top
  import sawlc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output logic           busy,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int LINES = SETS * WAYS;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_WB, S_FILL, S_ACC, S_DONE
  } state_t;

  state_t state_r;
  in_item_t req_r;
  logic [TAG_W-1:0] tags_r [LINES];
  logic [LINES-1:0] valid_r, dirty_r, rank_r;
  logic way_r, hit_r, wb_r;
  logic [OFF_W:0] cnt_r;     // counts words, extra bit for the pipeline tail
  logic [WORD_W-1:0] line_q, back_q;
  logic [OFF_W-1:0] cnt_d_r; // address of the word arriving from memory
  logic cnt_dv_r;

  logic [WORD_W-1:0] line_mem [SETS*WAYS*LINE_WORDS];
  logic [WORD_W-1:0] back_mem [SETS*TAGS_PER_SET*LINE_WORDS];

  logic [$clog2(LINES)-1:0] l0, l1, lsel;
  assign l0   = {req_r.set_index, 1'b0};
  assign l1   = {req_r.set_index, 1'b1};
  assign lsel = {req_r.set_index, way_r};

  // lookup
  logic m0, m1, vic;
  assign m0  = valid_r[l0] && tags_r[l0] == req_r.tag;
  assign m1  = valid_r[l1] && tags_r[l1] == req_r.tag;
  assign vic = !valid_r[l0] ? 1'b0 : !valid_r[l1] ? 1'b1 : rank_r[l1];

  // memory ports
  logic              lm_we, bm_we;
  logic [LINE_ADDR_W-1:0] lm_a;
  logic [BACK_ADDR_W-1:0] bm_a;
  logic [WORD_W-1:0] lm_d, bm_d;

  always_comb begin
    lm_we = 1'b0; bm_we = 1'b0;
    lm_a  = {lsel, req_r.word_offset};
    bm_a  = {req_r.set_index, req_r.tag, cnt_r[OFF_W-1:0]};
    lm_d  = req_r.write_data; bm_d = req_r.write_data;
    case (state_r)
      S_IDLE: begin
        bm_a  = {in_item.set_index, in_item.tag, in_item.word_offset};
        bm_we = start && !busy && in_item.command == CMD_LOAD;
        bm_d  = in_item.write_data;
      end
      S_WB: begin
        lm_a  = {lsel, cnt_r[OFF_W-1:0]};
        bm_a  = {req_r.set_index, tags_r[lsel], cnt_d_r};
        bm_we = cnt_dv_r;
        bm_d  = line_q;
      end
      S_FILL: begin
        lm_a  = {lsel, cnt_d_r};
        lm_we = cnt_dv_r;
        lm_d  = back_q;
      end
      S_ACC: lm_we = req_r.command == CMD_WRITE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lm_we) line_mem[lm_a] <= lm_d;
    line_q <= line_mem[lm_a];
    if (bm_we) back_mem[bm_a] <= bm_d;
    back_q <= back_mem[bm_a];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; dirty_r <= '0; out_valid <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        tags_r[i] <= '0;
        rank_r[i] <= i[0];
      end
      cnt_r <= '0; cnt_dv_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      cnt_d_r   <= cnt_r[OFF_W-1:0];
      cnt_dv_r  <= 1'b0;
      case (state_r)
        S_IDLE: if (start && !busy) begin
          req_r <= in_item;
          if (in_item.command == CMD_READ || in_item.command == CMD_WRITE)
            state_r <= S_LOOK;
          else begin
            out_valid <= 1'b1;
            out_item  <= '0;
          end
        end
        S_LOOK: begin
          cnt_r <= '0;
          hit_r <= m0 || m1;
          wb_r  <= 1'b0;
          if (m0 || m1) begin
            way_r <= m1; state_r <= S_ACC;
          end else begin
            way_r <= vic;
            if (valid_r[{req_r.set_index, vic}] && dirty_r[{req_r.set_index, vic}]) begin
              wb_r <= 1'b1; state_r <= S_WB;
            end else state_r <= S_FILL;
          end
        end
        S_WB, S_FILL: begin
          if (cnt_r[OFF_W]) begin
            cnt_r   <= '0;
            state_r <= (state_r == S_WB) ? S_FILL : S_ACC;
            if (state_r == S_FILL) begin
              tags_r[lsel] <= req_r.tag; valid_r[lsel] <= 1'b1;
              dirty_r[lsel] <= 1'b0;
            end
          end else begin
            cnt_r    <= cnt_r + 1'b1;
            cnt_dv_r <= 1'b1;
          end
        end
        S_ACC: begin
          if (req_r.command == CMD_WRITE) dirty_r[lsel] <= 1'b1;
          rank_r[lsel]  <= 1'b0;
          rank_r[{req_r.set_index, ~way_r}] <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_item.read_data  <= (req_r.command == CMD_READ) ? line_q : '0;
          out_item.hit        <= hit_r;
          out_item.wrote_back <= wb_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = state_r != S_IDLE || out_valid;

  // checks
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (rank_r[0] != rank_r[1]) && (rank_r[6] != rank_r[7])) else $error("lru");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.wrote_back |-> !out_item.hit) else $error("wb on hit");

endmodule
`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the two-way write-back LRU cache. Drives read, write, load and
// unknown command beats, predicts each result from its own copy of the lines,
// tags, LRU ranks and backing words, and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import sawlc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: cache predictor plus the queue of expected results
  class cache_scoreboard;

    logic [WORD_W-1:0] line_mem [SETS*WAYS*LINE_WORDS];
    bit                line_set [SETS*WAYS*LINE_WORDS]; // word ever given a value
    logic [TAG_W-1:0]  tags     [SETS*WAYS];
    bit                valid    [SETS*WAYS];
    bit                dirty    [SETS*WAYS];
    int                rank     [SETS*WAYS];
    logic [WORD_W-1:0] store    [SETS*TAGS_PER_SET*LINE_WORDS];
    bit                store_set[SETS*TAGS_PER_SET*LINE_WORDS];
    out_item_t         pending[$];
    int errors, beats, hits, writebacks;

    function new();
      for (int i = 0; i < SETS*WAYS; i++) begin
        tags[i] = '0; valid[i] = 0; dirty[i] = 0; rank[i] = i % WAYS;
      end
      foreach (line_set[i]) line_set[i] = 0;
      foreach (store_set[i]) store_set[i] = 0;
      errors = 0; beats = 0; hits = 0; writebacks = 0;
    endfunction

    function int find_way(int s, logic [TAG_W-1:0] t);
      for (int w = 0; w < WAYS; w++)
        if (valid[s*WAYS+w] && tags[s*WAYS+w] == t) return w;
      return -1;
    endfunction

    // a read may only return a word that has been given a value
    function bit readable(in_item_t it);
      int s, w;
      s = it.set_index;
      w = find_way(s, it.tag);
      if (w >= 0) return line_set[(s*WAYS+w)*LINE_WORDS + it.word_offset];
      return store_set[(s*TAGS_PER_SET + it.tag)*LINE_WORDS + it.word_offset];
    endfunction

    // note an accepted beat and queue its expected result
    function void note(in_item_t it);
      out_item_t r;
      int s, w, ln, row, old_row;
      r = '0;
      s = it.set_index;
      row = s*TAGS_PER_SET + it.tag;
      if (it.command == CMD_LOAD) begin
        store[row*LINE_WORDS + it.word_offset] = it.write_data;
        store_set[row*LINE_WORDS + it.word_offset] = 1;
      end else if (it.command == CMD_READ || it.command == CMD_WRITE) begin
        w = find_way(s, it.tag);
        if (w >= 0) begin
          r.hit = 1;
        end else begin
          // victim: lowest invalid way, else the highest rank
          w = -1;
          for (int v = 0; v < WAYS; v++)
            if (w < 0 && !valid[s*WAYS+v]) w = v;
          if (w < 0) begin
            w = 0;
            for (int v = 1; v < WAYS; v++)
              if (rank[s*WAYS+v] > rank[s*WAYS+w]) w = v;
          end
          ln = s*WAYS + w;
          if (valid[ln] && dirty[ln]) begin
            old_row = s*TAGS_PER_SET + tags[ln];
            for (int k = 0; k < LINE_WORDS; k++) begin
              store[old_row*LINE_WORDS+k]     = line_mem[ln*LINE_WORDS+k];
              store_set[old_row*LINE_WORDS+k] = line_set[ln*LINE_WORDS+k];
            end
            r.wrote_back = 1;
          end
          for (int k = 0; k < LINE_WORDS; k++) begin
            line_mem[ln*LINE_WORDS+k] = store[row*LINE_WORDS+k];
            line_set[ln*LINE_WORDS+k] = store_set[row*LINE_WORDS+k];
          end
          tags[ln] = it.tag; valid[ln] = 1; dirty[ln] = 0;
        end
        ln = s*WAYS + w;
        if (it.command == CMD_READ) begin
          r.read_data = line_mem[ln*LINE_WORDS + it.word_offset];
        end else begin
          line_mem[ln*LINE_WORDS + it.word_offset] = it.write_data;
          line_set[ln*LINE_WORDS + it.word_offset] = 1;
          dirty[ln] = 1;
        end
        // LRU update
        for (int v = 0; v < WAYS; v++)
          if (rank[s*WAYS+v] < rank[ln]) rank[s*WAYS+v]++;
        rank[ln] = 0;
      end
      hits += r.hit;
      writebacks += r.wrote_back;
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare a result beat with the oldest expectation
    task check(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = pending.pop_front();
        beats++;
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.hit !== want.hit)
          report($sformatf("hit %b, expected %b", got.hit, want.hit));
        if (got.wrote_back !== want.wrote_back)
          report($sformatf("wrote_back %b, expected %b", got.wrote_back, want.wrote_back));
      end
    endtask
  endclass

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_BEATS = 1530;
  localparam int QUIET_TAIL   = 200;
  localparam longint CYCLE_LIMIT = 2000000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  in_item_t  in_item = '0;
  logic      busy, out_valid;
  out_item_t out_item;
  longint    cycles = 0;

  cache_scoreboard sb = new();

  set_assoc_writeback_lru_cache_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) sb.check(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // present one beat and hold it until taken
  task send(in_item_t it);
    bit taken;
    taken = 0;
    @(negedge clk);
    start <= 1;
    in_item <= it;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1;
    end
    sb.note(it);
  endtask

  task pause(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 0;
    end
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function in_item_t beat(logic [CMD_W-1:0] c, int s, int t, int o, logic [31:0] d);
    in_item_t it;
    it.command = c; it.set_index = SET_W'(s); it.tag = TAG_W'(t);
    it.word_offset = OFF_W'(o);
    it.write_data = d;
    return it;
  endfunction

  // random beat, biased to few tags and offsets so lines get reused
  function in_item_t random_beat();
    in_item_t it;
    int p;
    it.write_data = $urandom;
    it.set_index  = SET_W'($urandom_range(0, SETS-1));
    it.tag = TAG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
    it.word_offset = OFF_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(0, 63));
    p = $urandom_range(0, 99);
    if (p < 40)      it.command = CMD_READ;
    else if (p < 70) it.command = CMD_WRITE;
    else if (p < 97) it.command = CMD_LOAD;
    else             it.command = CMD_NONE;
    if (it.command == CMD_READ && !sb.readable(it)) it.command = CMD_LOAD;
    return it;
  endfunction

  initial begin
    pause(2);
    @(negedge clk) rst_n <= 1;

    // directed: loads at the extremes, then reads of them
    send(beat(CMD_LOAD, 3, 15, 63, 32'h8000_0000));
    send(beat(CMD_LOAD, 0, 0, 0, 32'h7fff_ffff));
    send(beat(CMD_LOAD, 0, 0, 1, 32'hffff_ffff));
    send(beat(CMD_READ, 3, 15, 63, 0));
    send(beat(CMD_READ, 0, 0, 0, 0));
    send(beat(CMD_READ, 0, 0, 1, 0));
    send(beat(CMD_NONE, 2, 9, 33, 32'h5a5a_5a5a));
    // write hit, then fill the other way and evict a dirty line
    send(beat(CMD_WRITE, 0, 0, 0, 32'h0000_0000));
    send(beat(CMD_WRITE, 0, 1, 5, 32'h1234_5678));
    send(beat(CMD_READ, 0, 0, 0, 0));
    send(beat(CMD_WRITE, 0, 2, 63, 32'hdead_beef));
    send(beat(CMD_READ, 0, 2, 63, 0));
    // stale copy: load a cached row, then read it while the row stays cached
    send(beat(CMD_LOAD, 0, 0, 1, 32'h0bad_cafe));
    send(beat(CMD_READ, 0, 0, 1, 0));
    send(beat(CMD_WRITE, 0, 3, 0, 32'h0f0f_0f0f));
    send(beat(CMD_READ, 0, 0, 1, 0));
    send(beat(CMD_READ, 0, 1, 5, 0));
    send(beat(CMD_NONE, 0, 0, 0, 0));
    pause(1);

    // hold off until the cache is quiet
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 5));
      send(random_beat());
    end
    pause(1);

    drain();
    repeat (20) @(posedge clk);
    $display("%0d results checked: %0d hits, %0d dirty write-backs",
             sb.beats, sb.hits, sb.writebacks);
    $display("read, write, load and unknown commands with random idling");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
